// ----- hw/rtl/csfw_pkg.sv -----
// Shared widths, codes and limits for the counting semaphore with a waiter queue.
`default_nettype none

package csfw_pkg;

   // Field widths fixed by the item format.
   localparam int CNT_W  = 16;
   localparam int INIT_W = 15;
   localparam int ID_W   = 8;

   // Limits of the two's complement count.
   localparam logic signed [CNT_W-1:0] COUNT_MAX = 16'sh7FFF;
   localparam logic signed [CNT_W-1:0] COUNT_MIN = 16'sh8000;

   // Operation codes carried by an input item.
   typedef enum logic [1:0] {
      MODE_WAIT   = 2'd0,
      MODE_SIGNAL = 2'd1,
      MODE_RELOAD = 2'd2
   } mode_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_SATURATED = 2'd2
   } status_type;

endpackage : csfw_pkg

`default_nettype wire

// ----- hw/rtl/counting_semaphore_fifo_waiters_top.sv -----
// Counting semaphore with a first-in first-out queue of blocked waiters.
// An item is accepted in the idle state; its result is registered when the item commits in the
// execute state and is offered on the result channel from then on. An item is accepted only
// while idle, so a new item is not taken until the last one has committed; the registered read
// of the waiter memory at the queue head lands before the item commits; a stalled result delays it.
// Reset clears the count, the queue pointers, the reload value and all handshake state.
// The waiter memory is not cleared; only entries written by a wait are ever read back.
`default_nettype none

module counting_semaphore_fifo_waiters_top
   import csfw_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_BITS     = 8
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   // Configuration port.
   input  wire logic                    csr_wr_en,
   input  wire logic [INIT_W-1:0]       csr_wr_data,
   // Input channel.
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [1:0]              req_mode,
   input  wire logic [ID_W-1:0]         req_waiter_id,
   // Result channel.
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic signed [CNT_W-1:0]      rsp_count_after,
   output logic                         rsp_must_block,
   output logic                         rsp_woke_valid,
   output logic [ID_W-1:0]              rsp_woke_id,
   output logic [1:0]                   rsp_status
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
   // Unit step of the count, sized so it never sign-extends to minus one.
   localparam logic signed [CNT_W-1:0] COUNT_ONE = CNT_W'(1);
   // A wait at or below this count finds the queue full.
   localparam logic signed [CNT_W-1:0] COUNT_FLOOR = CNT_W'(-QUEUE_DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type                   state_ff, state_in;
   logic signed [CNT_W-1:0]     count_ff, count_in;
   logic [PTR_W-1:0]            head_ff, head_in;
   logic [PTR_W-1:0]            tail_ff, tail_in;
   logic [INIT_W-1:0]           init_ff;
   logic [1:0]                  mode_ff;
   logic [ID_BITS-1:0]          id_ff;
   logic [ID_BITS-1:0]          rd_data_ff;
   logic [ID_BITS-1:0]          queue_mem [QUEUE_DEPTH];

   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [CNT_W-1:0]     rsp_count_ff, rsp_count_in;
   logic                        rsp_block_ff, rsp_block_in;
   logic                        rsp_woke_ff, rsp_woke_in;
   logic [ID_W-1:0]             rsp_id_ff, rsp_id_in;
   status_type                  rsp_status_ff, rsp_status_in;

   logic                        req_fire;
   logic                        commit;
   logic                        mem_wr;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   // The item commits once the output register is free or being drained.
   assign commit    = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);

   // Reload value register.
   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff <= '0;
      end else if (csr_wr_en) begin
         init_ff <= csr_wr_data;
      end
   end

   // Latch the accepted item.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         mode_ff <= req_mode;
         id_ff   <= ID_BITS'(req_waiter_id);
      end
   end

   // Waiter memory: write at the tail, registered read at the head.
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         queue_mem[tail_ff] <= id_ff;
      end
      rd_data_ff <= queue_mem[head_ff];
   end

   // Execute the item: count update, pointer moves and the result fields.
   always_comb begin
      count_in      = count_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      mem_wr        = 1'b0;
      rsp_block_in  = 1'b0;
      rsp_woke_in   = 1'b0;
      rsp_id_in     = '0;
      rsp_status_in = STATUS_OK;
      if (commit) begin
         unique case (mode_ff)
            MODE_WAIT: begin
               if (count_ff > 0) begin
                  count_in = count_ff - COUNT_ONE;
               end else if (count_ff <= COUNT_FLOOR || count_ff == COUNT_MIN) begin
                  rsp_status_in = STATUS_FULL;
               end else begin
                  mem_wr       = 1'b1;
                  tail_in      = (tail_ff == PTR_LAST) ? '0 : tail_ff + PTR_ONE;
                  count_in     = count_ff - COUNT_ONE;
                  rsp_block_in = 1'b1;
               end
            end
            MODE_SIGNAL: begin
               if (count_ff < 0) begin
                  rsp_woke_in = 1'b1;
                  rsp_id_in   = ID_W'(rd_data_ff);
                  head_in     = (head_ff == PTR_LAST) ? '0 : head_ff + PTR_ONE;
                  count_in    = count_ff + COUNT_ONE;
               end else if (count_ff >= COUNT_MAX) begin
                  rsp_status_in = STATUS_SATURATED;
               end else begin
                  count_in = count_ff + COUNT_ONE;
               end
            end
            MODE_RELOAD: begin
               count_in = $signed({1'b0, init_ff});
               head_in  = '0;
               tail_in  = '0;
            end
            default: begin
               // The unused code leaves everything as it is.
            end
         endcase
      end
      rsp_count_in = count_in;
   end

   // Sequencer and output register control.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (commit) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_count_ff  <= rsp_count_in;
         rsp_block_ff  <= rsp_block_in;
         rsp_woke_ff   <= rsp_woke_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_count_after = rsp_count_ff;
   assign rsp_must_block  = rsp_block_ff;
   assign rsp_woke_valid  = rsp_woke_ff;
   assign rsp_woke_id     = rsp_id_ff;
   assign rsp_status      = rsp_status_ff;

   // With a non-negative count no waiter is queued, so the pointers meet.
   assert property (@(posedge clock) disable iff (reset)
      (count_ff >= 0) |-> (head_ff == tail_ff))
      else $error("queue pointers differ while no waiter is queued");

   // A committed item always shows up on the result channel.
   assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid)
      else $error("committed item did not produce a result");

   // A result never both blocks a waiter and wakes one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_must_block && rsp_woke_valid))
      else $error("result both blocks and wakes a waiter");

   // A refused wait happens only when the count is at or below zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_FULL) |-> (rsp_count_after <= 0))
      else $error("queue full reported with a positive count");

   // An accepted item always moves on into execution; no new item is taken while one is in execution.
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_EXEC))
      else $error("accepted item did not enter execution");

endmodule : counting_semaphore_fifo_waiters_top

`default_nettype wire

// ----- tb/sv/tb_counting_semaphore_fifo_waiters_top.sv -----
// Self-checking testbench for the counting semaphore with a first-in first-out waiter queue.
`default_nettype none

module tb_counting_semaphore_fifo_waiters_top;
   import csfw_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUEUE_DEPTH = 16;
   localparam int ID_BITS     = 8;
   localparam int HOLD_CYCLES = 200;
   localparam int PHASE_OPS   = 160;

   // Mode 3 has no operation; the block must report the count and change nothing.
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_kind_type;

   typedef struct packed {
      logic [1:0]      mode;
      logic [ID_W-1:0] waiter_id;
   } sem_req_type;

   typedef struct packed {
      logic signed [CNT_W-1:0] count_after;
      logic                    must_block;
      logic                    woke_valid;
      logic [ID_W-1:0]         woke_id;
      status_type              status;
   } sem_outcome_type;

   logic                    clock         = 1'b0;
   logic                    reset         = 1'b1;
   logic                    csr_wr_en     = 1'b0;
   logic [INIT_W-1:0]       csr_wr_data   = '0;
   logic                    req_valid     = 1'b0;
   logic                    req_ready;
   logic [1:0]              req_mode      = MODE_WAIT;
   logic [ID_W-1:0]         req_waiter_id = '0;
   logic                    rsp_valid;
   logic                    rsp_ready     = 1'b0;
   logic signed [CNT_W-1:0] rsp_count_after;
   logic                    rsp_must_block;
   logic                    rsp_woke_valid;
   logic [ID_W-1:0]         rsp_woke_id;
   logic [1:0]              rsp_status;

   // Items waiting to be offered, and outcomes predicted for accepted items.
   sem_req_type     pending_ops[$];
   sem_outcome_type pending_outcomes[$];

   // Shadow of the semaphore: count, blocked waiters in arrival order, reload value.
   logic signed [CNT_W-1:0] sem_count = '0;
   logic [ID_W-1:0]         blocked_ids[$];
   logic [INIT_W-1:0]       reload_value = '0;

   idle_kind_type idle_mode     = IDLE_NONE;
   int            hold_requests = 0;
   int            hold_seen     = 0;
   int            hold_left     = 0;
   int            mismatch_count = 0;
   sem_req_type   next_op;
   logic          send_gap;

   counting_semaphore_fifo_waiters_top #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .ID_BITS    (ID_BITS)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_waiter_id  (req_waiter_id),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_count_after(rsp_count_after),
      .rsp_must_block (rsp_must_block),
      .rsp_woke_valid (rsp_woke_valid),
      .rsp_woke_id    (rsp_woke_id),
      .rsp_status     (rsp_status)
   );

   always #5 clock = ~clock;

   // Applies one operation to the shadow semaphore and returns the outcome it should report.
   function automatic sem_outcome_type apply_semaphore_op(input logic [1:0] op,
                                                          input logic [ID_W-1:0] id);
      sem_outcome_type res;
      res = '0;
      case (op)
         MODE_WAIT: begin
            if (sem_count <= 0) begin
               // A full queue or a count at its floor refuses the waiter.
               if (blocked_ids.size() >= QUEUE_DEPTH || sem_count == COUNT_MIN) begin
                  res.status = STATUS_FULL;
               end else begin
                  blocked_ids.push_back(id);
                  sem_count      = sem_count - 1;
                  res.must_block = 1'b1;
               end
            end else begin
               sem_count = sem_count - 1;
            end
         end
         MODE_SIGNAL: begin
            if (sem_count < 0) begin
               res.woke_valid = 1'b1;
               res.woke_id    = blocked_ids.pop_front();
               sem_count      = sem_count + 1;
            end else if (sem_count == COUNT_MAX) begin
               res.status = STATUS_SATURATED;
            end else begin
               sem_count = sem_count + 1;
            end
         end
         MODE_RELOAD: begin
            sem_count = {1'b0, reload_value};
            blocked_ids.delete();
         end
         default: begin
         end
      endcase
      res.count_after = sem_count;
      return res;
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // Driver: offers queued items and predicts the outcome of each accepted one.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         sem_count = '0;
         blocked_ids.delete();
      end else begin
         if (req_valid && req_ready) begin
            pending_outcomes.push_back(apply_semaphore_op(req_mode, req_waiter_id));
         end
         if (!req_valid || req_ready) begin
            send_gap = (idle_mode == IDLE_SENDER && $urandom_range(99) < 74) ||
                       (idle_mode == IDLE_BOTH && $urandom_range(99) < 11);
            if (pending_ops.size() != 0 && !send_gap) begin
               next_op = pending_ops.pop_front();
               req_valid     <= 1'b1;
               req_mode      <= next_op.mode;
               req_waiter_id <= next_op.waiter_id;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off whenever one is requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !((idle_mode == IDLE_RECEIVER && $urandom_range(99) < 74) ||
                        (idle_mode == IDLE_BOTH && $urandom_range(99) < 11));
      end
   end

   // Monitor: each accepted result is checked against the oldest predicted outcome.
   always @(posedge clock) begin
      sem_outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            $error("result item with no outcome expected");
            mismatch_count++;
         end else begin
            want = pending_outcomes.pop_front();
            check_field("count_after", int'(want.count_after), int'(rsp_count_after));
            check_field("must_block", int'(want.must_block), int'(rsp_must_block));
            check_field("woke_valid", int'(want.woke_valid), int'(rsp_woke_valid));
            check_field("woke_id", int'(want.woke_id), int'(rsp_woke_id));
            check_field("status", int'(want.status), int'(rsp_status));
         end
      end
   end

   task automatic queue_op(input logic [1:0] op, input logic [ID_W-1:0] id);
      sem_req_type r;
      r.mode      = op;
      r.waiter_id = id;
      pending_ops.push_back(r);
   endtask

   // Random runs of waits or signals push the count to the full queue and back.
   task automatic queue_random_ops(input int n);
      int         pick;
      int         run;
      logic [1:0] op;
      while (n > 0) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            op = MODE_WAIT;
         end else if (pick < 90) begin
            op = MODE_SIGNAL;
         end else if (pick < 95) begin
            op = MODE_RELOAD;
         end else begin
            op = MODE_UNUSED;
         end
         run = (op == MODE_WAIT || op == MODE_SIGNAL) ? $urandom_range(18, 1) : 1;
         repeat (run) begin
            queue_op(op, ID_W'($urandom_range(255)));
            n--;
         end
      end
   endtask

   // Sets the idling pattern and writes the reload value while the block is idle.
   task automatic begin_phase(input idle_kind_type how, input logic [INIT_W-1:0] init,
                              input bit with_hold);
      @(posedge clock);
      idle_mode   <= how;
      csr_wr_en   <= 1'b1;
      csr_wr_data <= init;
      reload_value = init;
      if (with_hold) begin
         hold_requests <= hold_requests + 1;
      end
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // Waits until every item is accepted and every result is in, then lets the pipe drain.
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_ops.size() != 0 || req_valid || pending_outcomes.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      int                i;
      logic [INIT_W-1:0] cfg_sweep[8];
      cfg_sweep    = '{15'd0, 15'd32767, 15'd3, 15'd0, 15'd1, 15'd32766, 15'd0, 15'd16};
      cfg_sweep[3] = INIT_W'($urandom_range(32767));
      cfg_sweep[6] = INIT_W'($urandom_range(32767));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Fill the queue to its depth, get refused, then wake the two oldest waiters.
      begin_phase(IDLE_NONE, '0, 1'b0);
      queue_op(MODE_WAIT, 8'h00);
      queue_op(MODE_WAIT, 8'hFF);
      for (i = 1; i <= 14; i++) begin
         queue_op(MODE_WAIT, ID_W'(8'h11 * i));
      end
      queue_op(MODE_WAIT, 8'h5A);
      queue_op(MODE_UNUSED, 8'hFF);
      queue_op(MODE_SIGNAL, 8'h00);
      queue_op(MODE_SIGNAL, 8'h00);
      queue_op(MODE_RELOAD, 8'h00);
      wait_idle();

      // Top of the count range: signals saturate there.
      begin_phase(IDLE_NONE, 15'd32767, 1'b0);
      queue_op(MODE_RELOAD, 8'h00);
      queue_op(MODE_SIGNAL, 8'h00);
      queue_op(MODE_WAIT, 8'h3C);
      queue_op(MODE_SIGNAL, 8'h00);
      queue_op(MODE_SIGNAL, 8'h00);
      wait_idle();

      // Random phases over all idling patterns; one phase holds off the receiver.
      for (i = 0; i < 8; i++) begin
         begin_phase(idle_kind_type'(i % 4), cfg_sweep[i], i == 4);
         queue_op(MODE_RELOAD, ID_W'($urandom_range(255)));
         queue_random_ops(PHASE_OPS);
         wait_idle();
      end

      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_counting_semaphore_fifo_waiters_top passed");
      end else begin
         $display("tb_counting_semaphore_fifo_waiters_top failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("tb_counting_semaphore_fifo_waiters_top failed");
      $finish;
   end

endmodule : tb_counting_semaphore_fifo_waiters_top

`default_nettype wire
